>>> rtl/lcd_window_fill_sequencer_defines.svh
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer_defines
// Assertion macros used by the top RTL file of the window fill sequencer.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_FILL_SEQUENCER_DEFINES_SVH
`define LCD_WINDOW_FILL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lwfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LWFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lwfs assertion failed");

`endif

>>> rtl/lwfs_pkg.sv
// ----------------------------------------------------------------------------
// lwfs_pkg
// Types and opcodes shared by the window fill sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lwfs_pkg;

    localparam logic [7:0] OP_COLSET = 8'h2a;
    localparam logic [7:0] OP_ROWSET = 8'h2b;
    localparam logic [7:0] OP_MEMWR  = 8'h2c;

    localparam logic [2:0] HDR_LAST = 3'd4;

    localparam logic        KIND_START   = 1'b0;
    localparam logic        KIND_ADVANCE = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_COLSET = 5'b00010,
        PH_ROWSET = 5'b00100,
        PH_MEMWR  = 5'b01000,
        PH_PIXELS = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  header_index;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] color;
        logic [31:0] pixels_left;
        logic        low_half_next;
    } t_state;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       is_data;
        logic       release_select;
        logic       draw_done;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:         PH_IDLE,
        header_index:  3'd0,
        x_start:       16'd0,
        x_end:         16'd0,
        y_start:       16'd0,
        y_end:         16'd0,
        color:         16'd0,
        pixels_left:   32'd0,
        low_half_next: 1'b0
    };

endpackage

`default_nettype wire

>>> rtl/lwfs_step.sv
// ----------------------------------------------------------------------------
// lwfs_step
// Next-state and result logic for one item of the window fill sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lwfs_step (
    input  wire lwfs_pkg::t_state  i_state,
    input  wire logic              i_kind,
    input  wire logic [15:0]       i_left_x,
    input  wire logic [15:0]       i_top_y,
    input  wire logic [15:0]       i_rect_width,
    input  wire logic [15:0]       i_rect_height,
    input  wire logic [15:0]       i_fill_color,
    output lwfs_pkg::t_state       o_state,
    output logic                   o_res_valid,
    output lwfs_pkg::t_result      o_result
);
    import lwfs_pkg::*;

    // Opcode at index 0, then start and end big-endian; release on the last.
    function automatic t_result header_byte(input logic [2:0] idx, input logic [7:0] op,
                                            input logic [15:0] s, input logic [15:0] e);
        t_result r;
        r = '0;
        case (idx)
            3'd0: begin
                r.byte_out = op;
            end
            3'd1: begin
                r.byte_out = s[15:8];
                r.is_data  = 1'b1;
            end
            3'd2: begin
                r.byte_out = s[7:0];
                r.is_data  = 1'b1;
            end
            3'd3: begin
                r.byte_out = e[15:8];
                r.is_data  = 1'b1;
            end
            default: begin
                r.byte_out       = e[7:0];
                r.is_data        = 1'b1;
                r.release_select = 1'b1;
            end
        endcase
        return r;
    endfunction

    logic last_pixel;

    assign last_pixel = (i_state.pixels_left <= 32'd1);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_result    = '0;
        if (i_kind == KIND_START) begin
            // start while busy is dropped
            if (i_state.phase == PH_IDLE) begin
                o_state.x_start       = i_left_x;
                o_state.x_end         = i_left_x + i_rect_width - 16'd1;
                o_state.y_start       = i_top_y;
                o_state.y_end         = i_top_y + i_rect_height - 16'd1;
                o_state.color         = i_fill_color;
                o_state.pixels_left   = 32'(i_rect_width) * 32'(i_rect_height);
                o_state.low_half_next = 1'b0;
                o_state.header_index  = 3'd0;
                o_state.phase         = PH_COLSET;
            end
        end else begin
            case (i_state.phase)
                PH_COLSET, PH_ROWSET: begin
                    o_res_valid = 1'b1;
                    if (i_state.phase == PH_COLSET) begin
                        o_result = header_byte(i_state.header_index, OP_COLSET,
                                               i_state.x_start, i_state.x_end);
                    end else begin
                        o_result = header_byte(i_state.header_index, OP_ROWSET,
                                               i_state.y_start, i_state.y_end);
                    end
                    if (i_state.header_index >= HDR_LAST) begin
                        o_state.header_index = 3'd0;
                        o_state.phase = (i_state.phase == PH_COLSET) ? PH_ROWSET : PH_MEMWR;
                    end else begin
                        o_state.header_index = i_state.header_index + 3'd1;
                    end
                end
                PH_MEMWR: begin
                    o_res_valid             = 1'b1;
                    o_result.byte_out       = OP_MEMWR;
                    o_result.release_select = 1'b1;
                    if (i_state.pixels_left == 32'd0) begin
                        // zero-area window ends here
                        o_result.draw_done = 1'b1;
                        o_state.phase      = PH_IDLE;
                    end else begin
                        o_state.low_half_next = 1'b0;
                        o_state.phase         = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    o_res_valid      = 1'b1;
                    o_result.is_data = 1'b1;
                    if (!i_state.low_half_next) begin
                        o_result.byte_out     = i_state.color[15:8];
                        o_state.low_half_next = 1'b1;
                    end else begin
                        o_result.byte_out       = i_state.color[7:0];
                        o_result.release_select = last_pixel;
                        o_result.draw_done      = last_pixel;
                        o_state.low_half_next   = 1'b0;
                        if (i_state.pixels_left != 32'd0) begin
                            o_state.pixels_left = i_state.pixels_left - 32'd1;
                        end
                        if (last_pixel) begin
                            o_state.pixels_left = 32'd0;
                            o_state.phase       = PH_IDLE;
                        end
                    end
                end
                default: begin
                    // idle advance: no result, no change
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/lcd_window_fill_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer
// Turns a window fill request into the byte stream for a serial RGB565 panel.
// ----------------------------------------------------------------------------
// A start item (kind 0) latches the window and color; each advance item
// (kind 1) yields one byte: column-set, row-set and memory-write headers,
// then width*height pixels high byte first. One item is accepted per clock
// while o_in_ready is high: the state register and the result register
// update on the same edge. o_in_ready drops only while the result register
// holds a byte that the sink has not taken. Starts during a fill and
// advances while idle are consumed without a result.
`default_nettype none

`include "lcd_window_fill_sequencer_defines.svh"

module lcd_window_fill_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_left_x,
    input  wire logic [15:0] i_top_y,
    input  wire logic [15:0] i_rect_width,
    input  wire logic [15:0] i_rect_height,
    input  wire logic [15:0] i_fill_color,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_byte_out,
    output logic             o_is_data,
    output logic             o_release_select,
    output logic             o_draw_done
);
    import lwfs_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    n_res_valid;
    logic    in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    lwfs_step u_step (
        .i_state       (r_state),
        .i_kind        (i_kind),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_fill_color  (i_fill_color),
        .o_state       (n_state),
        .o_res_valid   (n_res_valid),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept && n_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_res_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_out       = r_result.byte_out;
    assign o_is_data        = r_result.is_data;
    assign o_release_select = r_result.release_select;
    assign o_draw_done      = r_result.draw_done;

    `LWFS_ASSERT_IMPL(a_phase_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state.phase))
    `LWFS_ASSERT_IMPL(a_done_releases, i_clk, i_rst_n, o_out_valid && o_draw_done,
                      o_release_select)
    `LWFS_ASSERT_IMPL(a_cmd_opcode, i_clk, i_rst_n, o_out_valid && !o_is_data,
                      o_byte_out == OP_COLSET || o_byte_out == OP_ROWSET ||
                      o_byte_out == OP_MEMWR)
    `LWFS_ASSERT_IMPL(a_pixels_nonzero, i_clk, i_rst_n, r_state.phase == PH_PIXELS,
                      r_state.pixels_left != 32'd0)
    `LWFS_ASSERT_NEXT(a_busy_advance_emits, i_clk, i_rst_n,
                      in_accept && i_kind == KIND_ADVANCE && r_state.phase != PH_IDLE,
                      o_out_valid)

endmodule

`default_nettype wire

>>> test/lcd_window_fill_sequencer_test.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer_test
// Self-checking bench for the window fill sequencer. Directed items cover
// advances while idle, a zero-area window at the coordinate extremes with a
// start arriving mid-fill, and a single pixel. Random windows follow, each
// pulled out byte by byte under random source gaps and sink stalls. Every
// panel byte is checked against a local predictor of the byte stream.
// ----------------------------------------------------------------------------
module lcd_window_fill_sequencer_test;
    import lwfs_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 600;
    localparam int REPORT_MAX   = 10;
    localparam int SETTLE       = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic        i_kind        = KIND_ADVANCE;
    logic [15:0] i_left_x      = '0;
    logic [15:0] i_top_y       = '0;
    logic [15:0] i_rect_width  = '0;
    logic [15:0] i_rect_height = '0;
    logic [15:0] i_fill_color  = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_byte_out;
    logic        o_is_data;
    logic        o_release_select;
    logic        o_draw_done;

    // predictor state
    t_phase      fill_phase    = PH_IDLE;
    logic [2:0]  hdr_pos       = '0;
    logic [15:0] col_first     = '0;
    logic [15:0] col_last      = '0;
    logic [15:0] row_first     = '0;
    logic [15:0] row_last      = '0;
    logic [15:0] color_held    = '0;
    logic [31:0] pixels_to_go  = '0;
    logic        low_byte_next = 1'b0;
    t_result     panel_bytes_due[$];

    int mismatch_count = 0;
    int bytes_checked  = 0;
    int useful_items   = 0;
    int ignored_items  = 0;
    int fills_started  = 0;
    int empty_fills    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;
    int quiet_cycles   = 0;

    lcd_window_fill_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_left_x         (i_left_x),
        .i_top_y          (i_top_y),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_fill_color     (i_fill_color),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_out       (o_byte_out),
        .o_is_data        (o_is_data),
        .o_release_select (o_release_select),
        .o_draw_done      (o_draw_done)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Returns 1 when the item did something: a start taken while idle, or a
    // panel byte produced (queued as expected).
    function automatic bit predict_panel_byte(input logic kind, input logic [15:0] x, y,
                                              input logic [15:0] w, h, c);
        t_result     nxt;
        logic [7:0]  opcode;
        logic [15:0] lo_coord;
        logic [15:0] hi_coord;
        nxt = '0;
        if (kind == KIND_START) begin
            if (fill_phase != PH_IDLE) return 1'b0;
            col_first     = x;
            col_last      = x + w - 16'd1;
            row_first     = y;
            row_last      = y + h - 16'd1;
            color_held    = c;
            pixels_to_go  = {16'd0, w} * {16'd0, h};
            low_byte_next = 1'b0;
            hdr_pos       = '0;
            fill_phase    = PH_COLSET;
            return 1'b1;
        end
        case (fill_phase)
            PH_COLSET, PH_ROWSET: begin
                if (fill_phase == PH_COLSET) begin
                    opcode   = OP_COLSET;
                    lo_coord = col_first;
                    hi_coord = col_last;
                end else begin
                    opcode   = OP_ROWSET;
                    lo_coord = row_first;
                    hi_coord = row_last;
                end
                // opcode, then start and end big-endian
                nxt.is_data = (hdr_pos != 3'd0);
                case (hdr_pos)
                    3'd0: nxt.byte_out = opcode;
                    3'd1: nxt.byte_out = lo_coord[15:8];
                    3'd2: nxt.byte_out = lo_coord[7:0];
                    3'd3: nxt.byte_out = hi_coord[15:8];
                    default: begin
                        nxt.byte_out       = hi_coord[7:0];
                        nxt.release_select = 1'b1;
                    end
                endcase
                if (hdr_pos >= HDR_LAST) begin
                    hdr_pos    = '0;
                    fill_phase = (fill_phase == PH_COLSET) ? PH_ROWSET : PH_MEMWR;
                end else begin
                    hdr_pos++;
                end
            end
            PH_MEMWR: begin
                nxt.byte_out       = OP_MEMWR;
                nxt.release_select = 1'b1;
                if (pixels_to_go == 0) begin
                    nxt.draw_done = 1'b1;
                    fill_phase    = PH_IDLE;
                end else begin
                    low_byte_next = 1'b0;
                    fill_phase    = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                nxt.is_data = 1'b1;
                if (!low_byte_next) begin
                    nxt.byte_out  = color_held[15:8];
                    low_byte_next = 1'b1;
                end else begin
                    nxt.byte_out  = color_held[7:0];
                    low_byte_next = 1'b0;
                    if (pixels_to_go <= 1) begin
                        nxt.release_select = 1'b1;
                        nxt.draw_done      = 1'b1;
                        pixels_to_go       = '0;
                        fill_phase         = PH_IDLE;
                    end else begin
                        pixels_to_go--;
                    end
                end
            end
            default: begin
                fill_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
        panel_bytes_due.push_back(nxt);
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 25;
            default: return 60;
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [15:0] x, y, w, h, c);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_left_x      <= x;
        i_top_y       <= y;
        i_rect_width  <= w;
        i_rect_height <= h;
        i_fill_color  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_panel_byte(kind, x, y, w, h, c)) useful_items++;
        else ignored_items++;
    endtask

    task automatic send_noise(input logic kind);
        send_item(kind, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    // only called while idle, so the start is always taken
    task automatic start_fill(input logic [15:0] x, y, w, h, c);
        fills_started++;
        if (w == 0 || h == 0) empty_fills++;
        send_item(KIND_START, x, y, w, h, c);
    endtask

    // pull bytes until the draw is done, with stray starts mixed in
    task automatic run_fill_out(input int noise_pct);
        while (fill_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) send_noise(KIND_START);
            send_noise(KIND_ADVANCE);
        end
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (panel_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_idle_advance();
        send_noise(KIND_ADVANCE);
        send_noise(KIND_ADVANCE);
    endtask

    // Widest window with no rows: end column wraps, memory write ends the draw.
    task automatic test_empty_window_extremes();
        start_fill(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(KIND_ADVANCE, '0, '0, '0, '0, '0);
        send_item(KIND_START, '0, '0, '0, '0, '0);
        run_fill_out(0);
    endtask

    task automatic test_single_pixel();
        start_fill(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
        run_fill_out(0);
        wait_for_drain();
    endtask

    task automatic test_random_fills();
        int          target;
        int          pick;
        logic [15:0] w;
        logic [15:0] h;
        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target) begin
            src_idle_pct   = pick_pct();
            sink_stall_pct = pick_pct();
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(3, 1)) send_noise(KIND_ADVANCE);
            end else begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    w = 16'($urandom);
                    h = 16'($urandom);
                    if ($urandom_range(1) == 0) w = '0;
                    else h = '0;
                end else if (pick < 18) begin
                    w = 16'($urandom_range(64, 16));
                    h = 16'($urandom_range(2, 1));
                end else begin
                    w = 16'($urandom_range(4));
                    h = 16'($urandom_range(4));
                end
                start_fill(16'($urandom), 16'($urandom), w, h, 16'($urandom));
                run_fill_out(($urandom_range(3) == 0) ? 25 : 2);
            end
            if ($urandom_range(7) == 0) wait_for_drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else begin
            sink_hold = pick_gap(sink_stall_pct);
            i_out_ready <= (sink_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (panel_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: unexpected byte %02h dc=%0b rel=%0b done=%0b", $time,
                             o_byte_out, o_is_data, o_release_select, o_draw_done);
            end else begin
                want = panel_bytes_due.pop_front();
                if (o_byte_out !== want.byte_out || o_is_data !== want.is_data ||
                    o_release_select !== want.release_select ||
                    o_draw_done !== want.draw_done) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: byte %0d want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                 $time, bytes_checked, want.byte_out, want.is_data,
                                 want.release_select, want.draw_done, o_byte_out,
                                 o_is_data, o_release_select, o_draw_done);
                end
            end
        end
    end

    // ends the run if neither side moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_advance();
        test_empty_window_extremes();
        test_single_pixel();
        test_random_fills();
        wait_for_drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("fills: %0d started, %0d with zero area; %0d items sent, %0d ignored",
                 fills_started, empty_fills, useful_items + ignored_items, ignored_items);
        $display("panel bytes checked: %0d, mismatches: %0d", bytes_checked, mismatch_count);
        if (mismatch_count == 0 && panel_bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/lwfs_pkg.sv
rtl/lwfs_step.sv
rtl/lcd_window_fill_sequencer.sv
test/lcd_window_fill_sequencer_test.sv
